FILE: sv/utf8d_pkg.sv
// shared types and lead-byte decode for the utf-8 to ucs-2 stream decoder
`default_nettype none
package utf8d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned UNIT_W   = 16;
    localparam int unsigned MAX_OUT  = 6;
    localparam int unsigned HELD_N   = 4;
    localparam int unsigned CNT_W    = 3;

    // lead byte classes
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] LEAD5_MASK = 8'hFC;
    localparam logic [7:0] LEAD5_CODE = 8'hF8;
    localparam logic [7:0] LEAD6_MASK = 8'hFE;
    localparam logic [7:0] LEAD6_CODE = 8'hFC;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    // result of classifying a byte outside a sequence
    typedef struct packed {
        logic [CNT_W-1:0] more;   // continuation bytes to follow, 0 = no sequence
        logic [4:0]       bits;   // payload bits of the lead byte
    } t_fresh;

    // group of units produced by one input transfer
    typedef struct packed {
        logic [MAX_OUT-1:0][UNIT_W-1:0] units;
        logic [CNT_W-1:0]               count;
        logic                           eot;   // final unit is the terminator
    } t_burst;

    // buffer status seen by the input handshake
    typedef struct packed {
        logic empty;
        logic single;
    } t_buf_status;

    function automatic t_fresh utf8d_fresh(input logic [7:0] b);
        t_fresh f;
        f.more = '0;
        f.bits = '0;
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            f.more = 3'd1;
            f.bits = b[4:0];
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            f.more = 3'd2;
            f.bits = {1'b0, b[3:0]};
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            f.more = 3'd3;
            f.bits = {2'b0, b[2:0]};
        end else if ((b & LEAD5_MASK) == LEAD5_CODE) begin
            f.more = 3'd4;
            f.bits = {3'b0, b[1:0]};
        end else if ((b & LEAD6_MASK) == LEAD6_CODE) begin
            f.more = 3'd5;
            f.bits = {4'b0, b[0]};
        end
        return f;
    endfunction

endpackage
`default_nettype wire

FILE: sv/utf8d_core.sv
// sequence state and per-byte decode into a burst of units
`default_nettype none
module utf8d_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_take,
    input  wire logic [utf8d_pkg::BYTE_W-1:0] i_data_byte,
    output utf8d_pkg::t_burst                o_burst
);
    import utf8d_pkg::*;

    logic [CNT_W-1:0]  r_remain, n_remain;
    logic [UNIT_W-1:0] r_partial, n_partial;
    logic [BYTE_W-1:0] r_lead, n_lead;
    logic [CNT_W-1:0]  r_hcnt, n_hcnt;
    logic [BYTE_W-1:0] r_held [HELD_N];

    t_fresh            fresh;
    logic              is_cont;
    logic              fresh_emit;
    logic              brk;
    logic [CNT_W-1:0]  base;
    logic [UNIT_W-1:0] next_partial;
    logic              held_we;

    // decode of the incoming byte against the open sequence
    always_comb begin
        fresh        = utf8d_fresh(i_data_byte);
        is_cont      = (i_data_byte & CONT_MASK) == CONT_CODE;
        fresh_emit   = fresh.more == '0;
        next_partial = {r_partial[UNIT_W-7:0], i_data_byte[5:0]};
        brk          = (r_remain != '0) && !is_cont;
        base         = brk ? r_hcnt + 3'd1 : 3'd0;

        n_remain  = r_remain;
        n_partial = r_partial;
        n_lead    = r_lead;
        n_hcnt    = r_hcnt;
        held_we   = 1'b0;

        o_burst.units = '0;
        o_burst.count = '0;
        o_burst.eot   = 1'b0;

        if (r_remain != '0 && is_cont) begin
            // continuation inside an open sequence
            n_partial = next_partial;
            n_remain  = r_remain - 3'd1;
            if (r_remain == 3'd1) begin
                o_burst.units[0] = next_partial;
                o_burst.count    = 3'd1;
                n_hcnt           = '0;
            end else begin
                held_we = 1'b1;
                if (r_hcnt < 3'(HELD_N)) begin
                    n_hcnt = r_hcnt + 3'd1;
                end
            end
        end else begin
            // idle byte, or a byte breaking the sequence: replay then fresh
            for (int k = 0; k < MAX_OUT; k++) begin
                if (brk && k == 0) begin
                    o_burst.units[k] = {8'h00, r_lead};
                end else if (brk && k >= 1 && k <= int'(r_hcnt) && k <= HELD_N) begin
                    o_burst.units[k] = {8'h00, r_held[2'(k - 1)]};
                end else if (fresh_emit && k == int'(base)) begin
                    o_burst.units[k] = {8'h00, i_data_byte};
                end
            end
            o_burst.count = base + (fresh_emit ? 3'd1 : 3'd0);
            o_burst.eot   = fresh_emit && (i_data_byte == '0);
            if (brk) begin
                n_remain  = '0;
                n_hcnt    = '0;
                n_partial = '0;
            end
            if (!fresh_emit) begin
                n_lead    = i_data_byte;
                n_partial = {11'h000, fresh.bits};
                n_remain  = fresh.more;
                n_hcnt    = '0;
            end
        end
    end

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain  <= '0;
            r_partial <= '0;
            r_lead    <= '0;
            r_hcnt    <= '0;
        end else if (i_take) begin
            r_remain  <= n_remain;
            r_partial <= n_partial;
            r_lead    <= n_lead;
            r_hcnt    <= n_hcnt;
        end
    end

    // held continuation bytes, no reset
    always_ff @(posedge i_clk) begin
        if (i_take && held_we) begin
            r_held[r_hcnt[1:0]] <= i_data_byte;
        end
    end

endmodule
`default_nettype wire

FILE: sv/utf8d_burst.sv
// result buffer that plays out a burst of units one transfer at a time
`default_nettype none
module utf8d_burst (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  utf8d_pkg::t_burst                 i_burst,
    input  wire logic                         i_out_take,
    output logic                              o_valid,
    output logic [utf8d_pkg::UNIT_W-1:0]      o_code_unit,
    output logic                              o_end_of_text,
    output logic                              o_last,
    output utf8d_pkg::t_buf_status            o_status
);
    import utf8d_pkg::*;

    logic [MAX_OUT-1:0][UNIT_W-1:0] r_units;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_eot;

    // count and terminator flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_eot <= 1'b0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
            r_eot <= i_burst.eot;
        end else if (i_out_take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // unit shift line, head is the unit on offer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_units <= i_burst.units;
        end else if (i_out_take) begin
            r_units <= {{UNIT_W{1'b0}}, r_units[MAX_OUT-1:1]};
        end
    end

    assign o_valid         = r_cnt != '0;
    assign o_code_unit     = r_units[0];
    assign o_last          = r_cnt == 3'd1;
    assign o_end_of_text   = r_eot && (r_cnt == 3'd1);
    assign o_status.empty  = r_cnt == '0;
    assign o_status.single = r_cnt == 3'd1;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(MAX_OUT))
        else $error("burst count out of range");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == '0 || (r_cnt == 3'd1 && i_out_take)))
        else $error("burst loaded over pending units");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_take && !i_load) |=> r_cnt == $past(r_cnt) - 3'd1)
        else $error("burst count did not step on transfer");
    a_eot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_text) |-> o_last)
        else $error("terminator not on final unit");
`endif

endmodule
`default_nettype wire

FILE: sv/utf8_to_ucs2_stream_decoder.sv
// utf-8 to ucs-2 stream decoder top level
// latency: a unit is offered in the cycle after the byte that completes it is taken
// throughput: one byte per cycle while each byte yields at most one unit and
//   the output is not stalled; a byte that yields several units holds the input
//   as the result buffer plays them out one per transfer, until only the last is left
// reset: synchronous active-low i_rst_n clears the sequence state and the buffer
`default_nettype none
module utf8_to_ucs2_stream_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [utf8d_pkg::BYTE_W-1:0]  i_data_byte,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [utf8d_pkg::UNIT_W-1:0]       o_code_unit,
    output logic                               o_end_of_text,
    output logic                               o_last
);
    import utf8d_pkg::*;

    t_burst      burst;
    t_buf_status status;
    logic        in_take;
    logic        out_take;

    // handshakes: take a byte once the buffer is free by the next edge
    assign out_take = o_valid && !i_stall;
    assign o_stall  = !(status.empty || (status.single && !i_stall));
    assign in_take  = i_valid && !o_stall;

    utf8d_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (in_take),
        .i_data_byte (i_data_byte),
        .o_burst     (burst)
    );

    utf8d_burst u_burst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (in_take),
        .i_burst       (burst),
        .i_out_take    (out_take),
        .o_valid       (o_valid),
        .o_code_unit   (o_code_unit),
        .o_end_of_text (o_end_of_text),
        .o_last        (o_last),
        .o_status      (status)
    );

endmodule
`default_nettype wire
